// File: src/stpr_pkg.sv
package stpr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_PAINT  = 2'd1,
    OP_READ   = 2'd2,
    OP_RENORM = 2'd3
  } op_e;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

  localparam logic [8:0] DIM_RESET = 9'd256;
  localparam logic [7:0] WEIGHT_FULL = 8'd255;

  typedef logic [7:0] weight_t;

endpackage

// File: src/splat_texel_paint_renormalize_top.sv
// Channel     | Dir | Fields (from bit 0 up)
// s_axis      | in  | op[1:0] x_coord[17:2] z_coord[33:18] layer[35:34] paint_delta[44:36]
//             |     | weight_in0..3[76:45], zero fill to 80 bits
// m_axis      | out | weight_out0..3 [31:0]
// cfg         | in  | cfg_idx_i: 0 map_width, 1 map_height; cfg_wdata_i 9 bits
//
// Write and read pass address, read, modify and write-back; renormalize and paint
// add a prep step and, unless the texel is all-zero or full, the eight-step
// restoring divide (four lanes in parallel), a fix step and a sweep of up to four steps.
// After reset the texel memory is cleared one entry a cycle, all MAX_DIM*MAX_DIM
// entries, with s_axis_tready low. A result waits in the output register; the
// memory write-back of the next item holds while that register is still full.
module splat_texel_paint_renormalize_top
  import stpr_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // op, x_coord, z_coord, layer, paint_delta, weight_in0..3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // weight_out0, weight_out1, weight_out2, weight_out3
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int XW    = $clog2(MAX_DIM);
  localparam int PW    = XW + DW;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_ADDR  = 10'b0000000100,
    ST_RD    = 10'b0000001000,
    ST_MOD   = 10'b0000010000,
    ST_PREP  = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_FIX   = 10'b0010000000,
    ST_SWEEP = 10'b0100000000,
    ST_WB    = 10'b1000000000
  } state_e;

  function automatic weight_t sat8(input logic signed [11:0] v);
    weight_t r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 12'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [9:0] sum4(input weight_t a, input weight_t b,
                                      input weight_t c, input weight_t d);
    return 10'(a) + 10'(b) + 10'(c) + 10'(d);
  endfunction

  state_e          state_q, state_d;
  logic [8:0]      map_w_q, map_h_q;
  logic [AW-1:0]   clr_q;
  logic [2:0]      cnt_q;
  logic [1:0]      sw_q;
  logic            out_valid_q;
  logic [31:0]     out_data_q;

  logic [79:0]     in_q;
  logic [AW-1:0]   idx_q;
  logic [31:0]     rdata_q;
  weight_t         tex_q [4];
  logic [15:0]     rem_q [4];
  logic [9:0]      sum_q;
  logic [1:0]      big_q;

  logic [31:0]     texel_mem_q [DEPTH];

  logic            out_free, wb_fire, mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata, tex_packed;

  logic [DW-1:0]   dim_w, dim_h;
  logic [XW-1:0]   xc, zc;
  logic [PW-1:0]   prod;
  logic [AW-1:0]   idx_d;

  op_e             in_op;
  logic [1:0]      in_layer;
  logic [8:0]      in_delta;
  weight_t         mod_tex [4];
  logic [9:0]      prep_sum, cur_sum;
  logic [1:0]      prep_big;
  logic [16:0]     div_sh;
  logic [17:0]     div_diff [4];

  assign in_op    = op_e'(in_q[1:0]);
  assign in_layer = in_q[35:34];
  assign in_delta = in_q[44:36];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign wb_fire    = (state_q == ST_WB) && out_free;
  assign tex_packed = {tex_q[3], tex_q[2], tex_q[1], tex_q[0]};
  assign cur_sum    = sum4(tex_q[0], tex_q[1], tex_q[2], tex_q[3]);

  always_comb begin
    if (map_w_q == 9'd0) begin
      dim_w = DW'(1);
    end else if (32'(map_w_q) > 32'(MAX_DIM)) begin
      dim_w = DW'(MAX_DIM);
    end else begin
      dim_w = DW'(map_w_q);
    end
    if (map_h_q == 9'd0) begin
      dim_h = DW'(1);
    end else if (32'(map_h_q) > 32'(MAX_DIM)) begin
      dim_h = DW'(MAX_DIM);
    end else begin
      dim_h = DW'(map_h_q);
    end
    if (in_q[17]) begin
      xc = '0;
    end else if (in_q[17:2] > 16'(dim_w - DW'(1))) begin
      xc = XW'(dim_w - DW'(1));
    end else begin
      xc = XW'(in_q[17:2]);
    end
    if (in_q[33]) begin
      zc = '0;
    end else if (in_q[33:18] > 16'(dim_h - DW'(1))) begin
      zc = XW'(dim_h - DW'(1));
    end else begin
      zc = XW'(in_q[33:18]);
    end
    prod  = PW'(zc) * PW'(dim_w);
    idx_d = AW'(prod + PW'(xc));
  end

  always_comb begin
    logic signed [11:0] painted;
    painted = '0;
    for (int i = 0; i < 4; i++) begin
      mod_tex[i] = rdata_q[8*i +: 8];
    end
    case (in_op)
      OP_WRITE: begin
        for (int i = 0; i < 4; i++) begin
          mod_tex[i] = in_q[45 + 8*i +: 8];
        end
      end
      OP_PAINT: begin
        painted = $signed({4'b0, mod_tex[in_layer]})
                  + $signed({{3{in_delta[8]}}, in_delta});
        mod_tex[in_layer] = sat8(painted);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    prep_sum = sum4(tex_q[0], tex_q[1], tex_q[2], tex_q[3]);
    prep_big = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (tex_q[i] > tex_q[prep_big]) begin
        prep_big = 2'(i);
      end
    end
    div_sh = 17'(sum_q) << cnt_q;
    for (int i = 0; i < 4; i++) begin
      div_diff[i] = {2'b0, rem_q[i]} - {1'b0, div_sh};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RD;
      ST_RD:    state_d = ST_MOD;
      ST_MOD: begin
        if (in_op == OP_WRITE || in_op == OP_READ) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (prep_sum == 10'd0 || prep_sum == 10'd255) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:   if (cnt_q == 3'd0) state_d = ST_FIX;
      ST_FIX:   state_d = ST_SWEEP;
      ST_SWEEP: if (cur_sum == 10'd255 || sw_q == 2'd3) state_d = ST_WB;
      ST_WB:    if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      map_w_q     <= DIM_RESET;
      map_h_q     <= DIM_RESET;
      clr_q       <= '0;
      cnt_q       <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == REG_MAP_WIDTH) map_w_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == REG_MAP_HEIGHT) map_h_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_PREP) cnt_q <= 3'd7;
      else if (state_q == ST_DIV) cnt_q <= cnt_q - 3'd1;
      if (state_q == ST_FIX) sw_q <= 2'd0;
      else if (state_q == ST_SWEEP) sw_q <= sw_q + 2'd1;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
    if (state_q == ST_ADDR) idx_q <= idx_d;
    if (wb_fire) out_data_q <= tex_packed;
    case (state_q)
      ST_MOD: begin
        for (int i = 0; i < 4; i++) tex_q[i] <= mod_tex[i];
      end
      ST_PREP: begin
        sum_q <= prep_sum;
        big_q <= prep_big;
        if (prep_sum == 10'd0) begin
          tex_q[0] <= 8'd0;
          tex_q[1] <= WEIGHT_FULL;
          tex_q[2] <= 8'd0;
          tex_q[3] <= 8'd0;
        end
        for (int i = 0; i < 4; i++) begin
          rem_q[i] <= ({8'b0, tex_q[i]} * 16'd255) + 16'(prep_sum[9:1]);
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 4; i++) begin
          if (!div_diff[i][17]) rem_q[i] <= div_diff[i][15:0];
          tex_q[i] <= {tex_q[i][6:0], !div_diff[i][17]};
        end
      end
      ST_FIX: begin
        tex_q[big_q] <= sat8($signed({4'b0, tex_q[big_q]}) + 12'sd255
                             - $signed({2'b0, cur_sum}));
      end
      ST_SWEEP: begin
        if (cur_sum != 10'd255) begin
          tex_q[sw_q] <= sat8($signed({4'b0, tex_q[sw_q]}) + 12'sd255
                              - $signed({2'b0, cur_sum}));
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_re    = (state_q == ST_RD);
  assign mem_we    = (state_q == ST_CLEAR) || wb_fire;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? 32'd0 : tex_packed;

  always_ff @(posedge clk_i) begin
    if (mem_we) texel_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= texel_mem_q[idx_q];
  end

  a_wb_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && state_d == ST_IDLE) |-> out_free)
    else $error("write-back while output register full");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_WB))
    else $error("result raised outside write-back");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import stpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int MAP_CELLS = 65536;

  typedef struct packed {
    logic [31:0]        weights;      // weight_in3 .. weight_in0
    logic signed [8:0]  paint_delta;
    logic [1:0]         layer;
    logic signed [15:0] z_coord;
    logic signed [15:0] x_coord;
    op_e                op;
  } access_t;

  typedef struct packed {
    logic        typed;
    logic [31:0] want;
  } typed_texel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_wdata_i = '0;

  int src_idle_pct = 34;
  int sink_idle_pct = 72;
  int fail_cnt = 0;
  int idle_cycles = 0;
  int sent_cnt = 0;

  // predictor state
  bit [31:0]    texel_mem [MAP_CELLS];
  logic [8:0]   width_reg = DIM_RESET;
  logic [8:0]   height_reg = DIM_RESET;
  logic [31:0]  expected_texels [$];
  typed_texel_t typed_texels [$];
  access_t      directed_rows [$];
  typed_texel_t directed_wants [$];

  always #4 clk_i = ~clk_i;

  splat_texel_paint_renormalize_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic int sat_weight(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic int dim_used(logic [8:0] r);
    if (r == 0) return 1;
    if (r > DIM_RESET) return int'(DIM_RESET);
    return int'(r);
  endfunction

  function automatic int clamp_to(int c, int dim);
    if (c < 0) return 0;
    if (c > dim - 1) return dim - 1;
    return c;
  endfunction

  function automatic logic [31:0] renorm_texel(logic [31:0] t);
    int wgt [4];
    int fresh [4];
    int sum;
    int total;
    int lead;
    int adj;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      wgt[i] = int'(t[8*i +: 8]);
      sum += wgt[i];
    end
    if (sum == 0) return {8'd0, 8'd0, WEIGHT_FULL, 8'd0};
    if (sum == 255) return t;
    total = 0;
    lead = 0;
    for (int i = 0; i < 4; i++) begin
      fresh[i] = sat_weight((wgt[i] * 255 + sum / 2) / sum);
      total += fresh[i];
      if (wgt[i] > wgt[lead]) lead = i;
    end
    adj = sat_weight(fresh[lead] + 255 - total);
    total += adj - fresh[lead];
    fresh[lead] = adj;
    for (int i = 0; i < 4 && total != 255; i++) begin
      adj = sat_weight(fresh[i] + 255 - total);
      total += adj - fresh[i];
      fresh[i] = adj;
    end
    return {fresh[3][7:0], fresh[2][7:0], fresh[1][7:0], fresh[0][7:0]};
  endfunction

  function automatic logic [31:0] apply_access(access_t acc);
    int w;
    int h;
    int slot;
    int lane;
    logic [31:0] t;
    w = dim_used(width_reg);
    h = dim_used(height_reg);
    slot = clamp_to(int'($signed(acc.z_coord)), h) * w + clamp_to(int'($signed(acc.x_coord)), w);
    t = texel_mem[slot];
    case (acc.op)
      OP_WRITE: begin
        t = acc.weights;
      end
      OP_PAINT: begin
        lane = int'(acc.layer);
        t[8*lane +: 8] = 8'(sat_weight(int'(t[8*lane +: 8]) + int'($signed(acc.paint_delta))));
        t = renorm_texel(t);
      end
      OP_RENORM: begin
        t = renorm_texel(t);
      end
      default: ;
    endcase
    texel_mem[slot] = t;
    return t;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    access_t acc;
    typed_texel_t note;
    logic [31:0] guess;
    logic [31:0] want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_WIDTH:  width_reg = cfg_wdata_i;
        REG_MAP_HEIGHT: height_reg = cfg_wdata_i;
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      acc = access_t'(s_axis_tdata[76:0]);
      guess = apply_access(acc);
      note = typed_texels.pop_front();
      expected_texels.push_back(note.typed ? note.want : guess);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_texels.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = expected_texels.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_axis_tdata[8*i +: 8] !== want[8*i +: 8]) begin
            $error("weight_out%0d: expected %0d, got %0d", i, want[8*i +: 8],
                   m_axis_tdata[8*i +: 8]);
            fail_cnt++;
          end
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_row(op_e op, logic [15:0] x, logic [15:0] z, logic [1:0] layer,
                         logic [8:0] delta, logic [31:0] wts, logic typed, logic [31:0] want);
    access_t acc;
    acc.op = op;
    acc.x_coord = x;
    acc.z_coord = z;
    acc.layer = layer;
    acc.paint_delta = delta;
    acc.weights = wts;
    directed_rows.push_back(acc);
    directed_wants.push_back({typed, want});
  endtask

  task automatic push_item(access_t acc, typed_texel_t note);
    if (sent_cnt < 160) begin
      src_idle_pct = 34;
      sink_idle_pct = 72;
    end else if (sent_cnt < 320) begin
      src_idle_pct = 72;
      sink_idle_pct = 34;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, acc};
    typed_texels.push_back(note);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_map_size(logic [8:0] w, logic [8:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MAP_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= REG_MAP_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    // unknown index, must be dropped
    cfg_idx_i <= $urandom_range(1) ? 2'd2 : 2'd3;
    cfg_wdata_i <= 9'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coord(int dim);
    int hot;
    hot = (dim < 6) ? dim : 6;
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'(-1 - int'($urandom_range(2)));
      2: return 16'(dim + int'($urandom_range(3)));
      3: return 16'(dim - 1 - int'($urandom_range(hot - 1)));
      4: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom_range(hot - 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_weights();
    int a;
    int b;
    int c;
    logic [31:0] wts;
    case ($urandom_range(7))
      0: wts = '0;
      1: begin
        wts = '0;
        wts[8*$urandom_range(3) +: 8] = WEIGHT_FULL;
      end
      2: begin
        a = $urandom_range(255);
        b = $urandom_range(255 - a);
        c = $urandom_range(255 - a - b);
        wts = {8'(255 - a - b - c), 8'(c), 8'(b), 8'(a)};
      end
      3: begin
        wts = $urandom;
        wts[8*$urandom_range(3) +: 8] = 8'd0;
      end
      default: wts = $urandom;
    endcase
    return wts;
  endfunction

  function automatic access_t pick_access(int w, int h);
    access_t acc;
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) acc.op = OP_WRITE;
    else if (roll < 60) acc.op = OP_PAINT;
    else if (roll < 75) acc.op = OP_READ;
    else acc.op = OP_RENORM;
    acc.x_coord = pick_coord(w);
    acc.z_coord = pick_coord(h);
    acc.layer = 2'($urandom);
    case ($urandom_range(5))
      0: acc.paint_delta = 9'($urandom);
      1: acc.paint_delta = $urandom_range(1) ? 9'h100 : 9'h0ff;
      default: acc.paint_delta = 9'(int'($urandom_range(80)) - 40);
    endcase
    acc.weights = pick_weights();
    return acc;
  endfunction

  initial begin
    logic [8:0] phase_w [8];
    logic [8:0] phase_h [8];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(OP_READ,   16'h0000, 16'h0000, 2'd0, 9'h000, 32'h0,        1'b1, 32'h0);
    add_row(OP_READ,   16'h8000, 16'h8000, 2'd0, 9'h000, 32'h0,        1'b1, 32'h0);
    add_row(OP_READ,   16'h7fff, 16'h7fff, 2'd0, 9'h000, 32'h0,        1'b1, 32'h0);
    add_row(OP_RENORM, 16'h0005, 16'h0005, 2'd0, 9'h000, 32'h0,        1'b1, 32'h0000ff00);
    add_row(OP_WRITE,  16'h7fff, 16'h8000, 2'd0, 9'h000, 32'hffffffff, 1'b1, 32'hffffffff);
    add_row(OP_RENORM, 16'h7fff, 16'h8000, 2'd0, 9'h000, 32'h0,        1'b0, 32'h0);
    add_row(OP_WRITE,  16'h0001, 16'h0001, 2'd0, 9'h000, 32'h000000ff, 1'b1, 32'h000000ff);
    add_row(OP_RENORM, 16'h0001, 16'h0001, 2'd0, 9'h000, 32'h0,        1'b1, 32'h000000ff);
    add_row(OP_PAINT,  16'h0001, 16'h0001, 2'd0, 9'h100, 32'h0,        1'b1, 32'h0000ff00);
    add_row(OP_PAINT,  16'h0001, 16'h0001, 2'd3, 9'h0ff, 32'h0,        1'b0, 32'h0);
    add_row(OP_PAINT,  16'h0001, 16'h0001, 2'd2, 9'h101, 32'h0,        1'b0, 32'h0);
    add_row(OP_WRITE,  16'h0002, 16'h0000, 2'd0, 9'h000, 32'h04030201, 1'b1, 32'h04030201);
    add_row(OP_RENORM, 16'h0002, 16'h0000, 2'd0, 9'h000, 32'h0,        1'b0, 32'h0);
    add_row(OP_PAINT,  16'h0003, 16'h0003, 2'd1, 9'h001, 32'h0,        1'b0, 32'h0);
    add_row(OP_WRITE,  16'h000a, 16'h000a, 2'd0, 9'h000, 32'hfe017f80, 1'b1, 32'hfe017f80);
    add_row(OP_READ,   16'h000a, 16'h000a, 2'd0, 9'h000, 32'h0,        1'b1, 32'hfe017f80);
    add_row(OP_PAINT,  16'h000a, 16'h000a, 2'd2, 9'h064, 32'h0,        1'b0, 32'h0);
    add_row(OP_WRITE,  16'h0064, 16'h00c8, 2'd0, 9'h000, 32'hcc3355aa, 1'b1, 32'hcc3355aa);
    add_row(OP_RENORM, 16'h0064, 16'h00c8, 2'd0, 9'h000, 32'h0,        1'b0, 32'h0);
    add_row(OP_WRITE,  16'h0000, 16'h00ff, 2'd0, 9'h000, 32'h0,        1'b1, 32'h0);
    add_row(OP_PAINT,  16'h0000, 16'h00ff, 2'd3, 9'h1ff, 32'h0,        1'b1, 32'h0000ff00);

    foreach (directed_rows[i]) push_item(directed_rows[i], directed_wants[i]);

    phase_w = '{9'd256, 9'd5, 9'd0, 9'd511, 9'd1, 9'd256, 9'd17, 9'd1};
    phase_h = '{9'd256, 9'd3, 9'd0, 9'd511, 9'd256, 9'd1, 9'd9, 9'd1};
    foreach (phase_w[p]) begin
      drain_results();
      set_map_size(phase_w[p], phase_h[p]);
      repeat (57) begin
        push_item(pick_access(dim_used(phase_w[p]), dim_used(phase_h[p])), '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
